[src/assert_macros.svh]
// assertion helpers used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

[src/dmsh_pkg.sv]
// ----------------------------------------------------------------------------
// dmsh_pkg
// Shared types, multiplier constants and command struct for the dual
// multiply scramble hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmsh_pkg;

   localparam int unsigned WORD_W = 32;

   // configuration register indexes
   typedef enum logic {
      CSR_SEED_EVEN,
      CSR_SEED_ODD
   } csr_index_type;

   // one mixing step per cycle, five steps per absorbed word
   typedef enum logic [2:0] {
      STEP_MIX0,
      STEP_MIX1,
      STEP_MIX2,
      STEP_MIX3,
      STEP_MIX4
   } step_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load;
      logic     run;
      step_type step;
      logic     pos;
      logic     fold;
      logic     emit;
      logic     pair_ok;
   } cmd_type;

   // chain a multipliers, indexed by word position and step
   function automatic logic [WORD_W-1:0] mult_a_const(input logic pos, input logic [1:0] idx);
      logic [WORD_W-1:0] val;
      val = '0;
      case ({pos, idx})
         3'b000:  val = 32'hCF98B111;
         3'b001:  val = 32'h87085B9F;
         3'b010:  val = 32'h12CEB96D;
         3'b011:  val = 32'h257E1D83;
         3'b100:  val = 32'hA27416F5;
         3'b101:  val = 32'hD38396FF;
         3'b110:  val = 32'h7C932B89;
         3'b111:  val = 32'hBFA49F69;
         default: val = '0;
      endcase
      return val;
   endfunction

   // chain b multipliers, indexed by word position and step
   function automatic logic [WORD_W-1:0] mult_b_const(input logic pos, input logic [1:0] idx);
      logic [WORD_W-1:0] val;
      val = '0;
      case ({pos, idx})
         3'b000:  val = 32'hEF0569FB;
         3'b001:  val = 32'h689B6B9F;
         3'b010:  val = 32'h79F8A395;
         3'b011:  val = 32'hC3EFEA97;
         3'b100:  val = 32'hC31713DB;
         3'b101:  val = 32'hDDCD1F0F;
         3'b110:  val = 32'h59C3AF2D;
         3'b111:  val = 32'h35BD1EC9;
         default: val = '0;
      endcase
      return val;
   endfunction

   // exchange the 16-bit halves of a word
   function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] x);
      return {x[WORD_W/2-1:0], x[WORD_W-1:WORD_W/2]};
   endfunction

endpackage

[src/dmsh_ctrl.sv]
// ----------------------------------------------------------------------------
// dmsh_ctrl
// Sequencer: request handshake, word position tracking, the five-step
// mixing count and the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmsh_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_final_word,
   output logic             req_stall,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output dmsh_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   dmsh_pkg::step_type step_ff, step_in;
   logic               pos_ff, pos_in;
   logic               last_ff, last_in;
   logic               odd_ff, odd_in;
   logic               pair_ff, pair_in;
   logic               fold_ff, fold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load;
   logic               emit;
   logic               out_free;

   // output register may be refilled when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      odd_in       = odd_ff;
      pair_in      = pair_ff;
      fold_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load         = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_final_word;
               if (odd_ff) begin
                  // second word of a pair
                  load    = 1'b1;
                  pos_in  = 1'b1;
                  pair_in = 1'b1;
                  odd_in  = 1'b0;
                  step_in = dmsh_pkg::STEP_MIX0;
                  state_in = ST_RUN;
               end else if (!req_final_word) begin
                  // first word of a pair
                  load    = 1'b1;
                  pos_in  = 1'b0;
                  odd_in  = 1'b1;
                  step_in = dmsh_pkg::STEP_MIX0;
                  state_in = ST_RUN;
               end else begin
                  // unpaired last word is dropped
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            if (step_ff == dmsh_pkg::STEP_MIX4) begin
               fold_in  = 1'b1;
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               step_in = dmsh_pkg::step_type'(step_ff + 3'd1);
            end
         end
         ST_EMIT: begin
            // wait for the totals fold and a free output register
            if (!fold_ff && out_free) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               odd_in       = 1'b0;
               pair_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= dmsh_pkg::STEP_MIX0;
         pos_ff       <= 1'b0;
         last_ff      <= 1'b0;
         odd_ff       <= 1'b0;
         pair_ff      <= 1'b0;
         fold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         odd_ff       <= odd_in;
         pair_ff      <= pair_in;
         fold_ff      <= fold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   // command bundle
   assign cmd.load    = load;
   assign cmd.run     = (state_ff == ST_RUN);
   assign cmd.step    = step_ff;
   assign cmd.pos     = pos_ff;
   assign cmd.fold    = fold_ff;
   assign cmd.emit    = emit;
   assign cmd.pair_ok = pair_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_SAME(a_emit_needs_room, clock, reset, emit, !(rsp_valid_ff && rsp_stall))
   `ASSERT_NEXT(a_emit_sets_valid, clock, reset, emit, rsp_valid_ff)
   `ASSERT_SAME(a_no_emit_during_fold, clock, reset, fold_ff, !emit)

endmodule

[src/dmsh_datapath.sv]
// ----------------------------------------------------------------------------
// dmsh_datapath
// Seed registers, running sums and totals, two shared 32x32 multipliers
// stepping the two scramble chains, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmsh_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [dmsh_pkg::WORD_W-1:0]   csr_wr_data,
   input  logic [dmsh_pkg::WORD_W-1:0]   req_data_word,
   input  dmsh_pkg::cmd_type             cmd,
   output logic [dmsh_pkg::WORD_W-1:0]   rsp_hash_first,
   output logic [dmsh_pkg::WORD_W-1:0]   rsp_hash_second,
   output logic                          rsp_no_full_block
);

   logic [dmsh_pkg::WORD_W-1:0] seed_even_ff;
   logic [dmsh_pkg::WORD_W-1:0] seed_odd_ff;
   logic [dmsh_pkg::WORD_W-1:0] sum_a_ff;
   logic [dmsh_pkg::WORD_W-1:0] sum_b_ff;
   logic [dmsh_pkg::WORD_W-1:0] total_a_ff;
   logic [dmsh_pkg::WORD_W-1:0] total_b_ff;
   logic [dmsh_pkg::WORD_W-1:0] a_work_ff, a_work_in;
   logic [dmsh_pkg::WORD_W-1:0] b_work_ff, b_work_in;
   logic [dmsh_pkg::WORD_W-1:0] b_part_ff, b_part_in;
   logic [dmsh_pkg::WORD_W-1:0] hash_first_ff;
   logic [dmsh_pkg::WORD_W-1:0] hash_second_ff;
   logic                        no_full_ff;
   logic [dmsh_pkg::WORD_W-1:0] first_mult;
   logic [dmsh_pkg::WORD_W-1:0] mul_a_x, mul_a_y, prod_a;
   logic [dmsh_pkg::WORD_W-1:0] mul_b_x, mul_b_y, prod_b;
   logic [1:0]                  a_idx;

   // first multiplier of the set, low bit forced on
   assign first_mult = (cmd.pos ? seed_odd_ff : seed_even_ff) | 32'd1;

   // chain a operands: plain multiply, then swap-and-multiply
   assign a_idx   = 2'(cmd.step - 3'd1);
   assign mul_a_x = (cmd.step == dmsh_pkg::STEP_MIX0) ? a_work_ff
                                                      : dmsh_pkg::swap_halves(a_work_ff);
   assign mul_a_y = (cmd.step == dmsh_pkg::STEP_MIX0) ? first_mult
                                                      : dmsh_pkg::mult_a_const(cmd.pos, a_idx);
   assign prod_a  = 32'(mul_a_x * mul_a_y);

   // chain b operands and accumulation per step
   always_comb begin
      mul_b_x   = b_work_ff;
      mul_b_y   = first_mult;
      b_work_in = b_work_ff;
      b_part_in = b_part_ff;
      case (cmd.step)
         dmsh_pkg::STEP_MIX0: begin
            mul_b_x   = dmsh_pkg::swap_halves(b_work_ff);
            mul_b_y   = dmsh_pkg::mult_b_const(cmd.pos, 2'd0);
            b_part_in = prod_b;
         end
         dmsh_pkg::STEP_MIX1: begin
            mul_b_x   = b_work_ff;
            mul_b_y   = first_mult;
            b_work_in = b_part_ff + prod_b;
         end
         dmsh_pkg::STEP_MIX2: begin
            mul_b_x   = {16'd0, b_work_ff[dmsh_pkg::WORD_W-1:16]};
            mul_b_y   = dmsh_pkg::mult_b_const(cmd.pos, 2'd1);
            b_part_in = prod_b;
         end
         dmsh_pkg::STEP_MIX3: begin
            mul_b_x   = b_work_ff;
            mul_b_y   = dmsh_pkg::mult_b_const(cmd.pos, 2'd2);
            b_work_in = b_part_ff + prod_b;
         end
         dmsh_pkg::STEP_MIX4: begin
            mul_b_x   = dmsh_pkg::swap_halves(b_work_ff);
            mul_b_y   = dmsh_pkg::mult_b_const(cmd.pos, 2'd3);
            b_work_in = prod_b + b_work_ff;
         end
         default: begin
            b_work_in = b_work_ff;
         end
      endcase
   end

   assign prod_b = 32'(mul_b_x * mul_b_y);

   // chain a next value
   always_comb begin
      a_work_in = a_work_ff;
      if (cmd.load) begin
         a_work_in = sum_a_ff + req_data_word;
      end else if (cmd.run) begin
         a_work_in = prod_a;
      end
   end

   // seed registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_even_ff <= 32'd1;
         seed_odd_ff  <= 32'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            dmsh_pkg::CSR_SEED_EVEN: seed_even_ff <= csr_wr_data;
            dmsh_pkg::CSR_SEED_ODD:  seed_odd_ff  <= csr_wr_data;
            default:                 seed_even_ff <= seed_even_ff;
         endcase
      end
   end

   // working registers of the two chains
   always_ff @(posedge clock) begin
      a_work_ff <= a_work_in;
      if (cmd.load) begin
         b_work_ff <= sum_b_ff + req_data_word;
      end else if (cmd.run) begin
         b_work_ff <= b_work_in;
         b_part_ff <= b_part_in;
      end
   end

   // running sums and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         total_a_ff <= '0;
         total_b_ff <= '0;
      end else if (cmd.emit) begin
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         total_a_ff <= '0;
         total_b_ff <= '0;
      end else begin
         if (cmd.run && cmd.step == dmsh_pkg::STEP_MIX4) begin
            sum_a_ff <= prod_a;
            sum_b_ff <= b_work_in;
         end
         if (cmd.fold) begin
            total_a_ff <= total_a_ff + a_work_ff;
            total_b_ff <= total_b_ff + b_work_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         hash_first_ff  <= cmd.pair_ok ? (sum_a_ff ^ sum_b_ff) : '0;
         hash_second_ff <= cmd.pair_ok ? (total_a_ff ^ total_b_ff) : '0;
         no_full_ff     <= !cmd.pair_ok;
      end
   end

   assign rsp_hash_first    = hash_first_ff;
   assign rsp_hash_second   = hash_second_ff;
   assign rsp_no_full_block = no_full_ff;

endmodule

[src/dual_multiply_scramble_hash_unit.sv]
// ----------------------------------------------------------------------------
// dual_multiply_scramble_hash_unit
// Two-chain multiply and halfword-swap hash over a stream of 32-bit words,
// one result on the last word of each message.
//
//   channel   ports                                                    dir
//   request   req_valid req_stall req_data_word req_final_word         in
//   response  rsp_valid rsp_stall rsp_hash_first rsp_hash_second ...   out
//   csr       csr_wr_en csr_index csr_wr_data                          in
//
// On accept an absorbed word is added to the sums into the working registers,
// then in five steps two 32x32 multipliers each run one link of a chain.
// After the steps of every word the totals fold; a last word then waits for
// that fold and loads the result; an unpaired last word goes straight to the result load.
// Synchronous reset clears sums, totals and word position; seeds return to 1.
// The result register lets a new message start while a result is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_multiply_scramble_hash_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [dmsh_pkg::WORD_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dmsh_pkg::WORD_W-1:0] req_data_word,
   input  logic                        req_final_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dmsh_pkg::WORD_W-1:0] rsp_hash_first,
   output logic [dmsh_pkg::WORD_W-1:0] rsp_hash_second,
   output logic                        rsp_no_full_block
);

   dmsh_pkg::cmd_type cmd;

   // sequencer
   dmsh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_word (req_final_word),
      .req_stall      (req_stall),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   // arithmetic and storage
   dmsh_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_data_word     (req_data_word),
      .cmd               (cmd),
      .rsp_hash_first    (rsp_hash_first),
      .rsp_hash_second   (rsp_hash_second),
      .rsp_no_full_block (rsp_no_full_block)
   );

endmodule
